@@ design/wcs_pkg.sv @@
package wcs_pkg;

   // Graph size
   localparam int VERTEX_COUNT = 256;
   localparam int VTX_W        = $clog2(VERTEX_COUNT);

   // Seen-edge map: one bit per ordered pair {lo, hi}, packed into rows
   localparam int PAIR_W   = 2 * VTX_W;
   localparam int WORD_W   = (PAIR_W - 1 < 5) ? PAIR_W - 1 : 5;
   localparam int MAP_WORD = 2 ** WORD_W;
   localparam int ROW_W    = PAIR_W - WORD_W;
   localparam int MAP_ROWS = 2 ** ROW_W;

   // Clearing pass after reset covers both stores
   localparam int CLEAR_LEN = (MAP_ROWS > VERTEX_COUNT) ? MAP_ROWS : VERTEX_COUNT;
   localparam int CLR_W     = $clog2(CLEAR_LEN);

   localparam int QUEUE_DEPTH = 2;

   localparam int DEG_W   = 8;
   localparam int TOTAL_W = 23;
   localparam int SUM_W   = TOTAL_W + 1;

   localparam logic [DEG_W-1:0]   DEG_MAX   = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // edge_status codes
   localparam logic [1:0] ST_NEW   = 2'd0;
   localparam logic [1:0] ST_SELF  = 2'd1;
   localparam logic [1:0] ST_DUP   = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [7:0] vertex_a;
      logic [7:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] wedge_total;
      logic [1:0]         edge_status;
   } rsp_type;

   function automatic logic [DEG_W-1:0] sat_inc(input logic [DEG_W-1:0] d);
      return (d == DEG_MAX) ? d : d + 1'b1;
   endfunction

endpackage

@@ design/wcs_ram.sv @@
module wcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/wcs_queue.sv @@
module wcs_queue import wcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rsp_type    push_data,
   output logic       out_valid,
   input  logic       out_ready,
   output rsp_type    out_data,
   output logic [1:0] count
);

   rsp_type    slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/wedge_counter_edge_stream_core.sv @@
// Each result passes through the stage 1 and stage 2 registers into the result queue, which drives rsp_valid.
// A new edge is taken only while stage 1 is empty; the degree RAM has one read and one write port and
// each new edge reads and writes two degrees.
// Reset: synchronous; afterward a clearing pass zeroes the degree RAM and the seen-edge map,
// with req_ready low throughout.
module wedge_counter_edge_stream_core import wcs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Stage 1: map row and deg[lo] come back from the RAMs
   typedef struct packed {
      logic [VTX_W-1:0]  lo;
      logic [VTX_W-1:0]  hi;
      logic [ROW_W-1:0]  row;
      logic [WORD_W-1:0] bofs;
      logic [1:0]        status;
      logic              cand;    // in range, not a self-loop
   } stage1_type;

   // Stage 2: deg[hi] comes back, total is updated
   typedef struct packed {
      logic [VTX_W-1:0] hi;
      logic [1:0]       status;
      logic             counted;
      logic [DEG_W-1:0] deg_lo;
   } stage2_type;

   logic             clear_ff, clear_in;
   logic [CLR_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic       s1_valid_ff, s1_valid_in;
   stage1_type s1_ff, s1_in;
   logic       s2_valid_ff, s2_valid_in;
   stage2_type s2_ff, s2_in;

   logic [TOTAL_W-1:0] acc_ff, acc_in;

   // bypass of the deg[hi] write that lands on the same edge as the next deg[lo] read
   logic             fwd_valid_ff, fwd_valid_in;
   logic [VTX_W-1:0] fwd_addr_ff, fwd_addr_in;
   logic [DEG_W-1:0] fwd_data_ff, fwd_data_in;

   // RAM ports
   logic                deg_we;
   logic [VTX_W-1:0]    deg_waddr, deg_raddr;
   logic [DEG_W-1:0]    deg_wdata, deg_rdata;
   logic                map_we;
   logic [ROW_W-1:0]    map_waddr, map_raddr;
   logic [MAP_WORD-1:0] map_wdata, map_rdata;

   // decode of the incoming edge
   logic [VTX_W-1:0]  va, vb, lo, hi;
   logic [PAIR_W-1:0] pair;
   logic              out_range;
   logic              req_xfer;

   logic [DEG_W-1:0] deg_lo, deg_hi;
   logic             hit, s1_new, s2_new;
   logic [SUM_W-1:0] sum;

   logic       q_push;
   rsp_type    q_data;
   logic [1:0] q_count;

   // ---------------- input decode ----------------
   always_comb begin
      va        = VTX_W'(req_data.vertex_a);
      vb        = VTX_W'(req_data.vertex_b);
      out_range = (32'(req_data.vertex_a) >= VERTEX_COUNT) ||
                  (32'(req_data.vertex_b) >= VERTEX_COUNT);
      lo        = (va < vb) ? va : vb;
      hi        = (va < vb) ? vb : va;
      pair      = {lo, hi};
   end

   // one edge in flight through the RAM stages; results need a free queue slot
   assign req_ready = !clear_ff && !s1_valid_ff &&
                      ((3'(q_count) + 3'(s2_valid_ff)) < 3'(QUEUE_DEPTH));
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = req_xfer;
      s1_in.lo    = lo;
      s1_in.hi    = hi;
      s1_in.row   = pair[PAIR_W-1:WORD_W];
      s1_in.bofs  = pair[WORD_W-1:0];
      s1_in.cand  = !out_range && (va != vb);
      if (out_range) begin
         s1_in.status = ST_RANGE;
      end else if (va == vb) begin
         s1_in.status = ST_SELF;
      end else begin
         s1_in.status = ST_NEW;
      end
   end

   // read addresses: deg[lo] on transfer, deg[hi] the cycle after
   assign map_raddr = pair[PAIR_W-1:WORD_W];
   assign deg_raddr = s1_valid_ff ? s1_ff.hi : lo;

   // ---------------- stage 1 ----------------
   always_comb begin
      deg_lo = (fwd_valid_ff && (fwd_addr_ff == s1_ff.lo)) ? fwd_data_ff : deg_rdata;
      hit    = map_rdata[s1_ff.bofs];
      s1_new = s1_valid_ff && s1_ff.cand && !hit;

      s2_valid_in    = s1_valid_ff;
      s2_in.hi       = s1_ff.hi;
      s2_in.counted  = s1_new;
      s2_in.deg_lo   = deg_lo;
      s2_in.status   = s1_ff.cand ? (hit ? ST_DUP : ST_NEW) : s1_ff.status;
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      deg_hi = deg_rdata;
      s2_new = s2_valid_ff && s2_ff.counted;
      // both saturating adds collapse into one: the clamp is monotone
      sum    = {1'b0, acc_ff} + SUM_W'(s2_ff.deg_lo) + SUM_W'(deg_hi);
      acc_in = acc_ff;
      if (s2_new) begin
         acc_in = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      end

      fwd_valid_in = !clear_ff && s2_new;
      fwd_addr_in  = s2_ff.hi;
      fwd_data_in  = sat_inc(deg_hi);

      q_push             = s2_valid_ff;
      q_data.wedge_total = acc_in;
      q_data.edge_status = s2_ff.status;
   end

   // ---------------- RAM writes ----------------
   // stage 1 and stage 2 never hold an edge in the same cycle, so one write port suffices
   always_comb begin
      deg_we    = 1'b0;
      deg_waddr = s1_ff.lo;
      deg_wdata = sat_inc(deg_lo);
      map_we    = 1'b0;
      map_waddr = s1_ff.row;
      map_wdata = map_rdata | (MAP_WORD'(1) << s1_ff.bofs);
      if (clear_ff) begin
         deg_we    = (32'(clr_cnt_ff) < VERTEX_COUNT);
         deg_waddr = clr_cnt_ff[VTX_W-1:0];
         deg_wdata = '0;
         map_we    = (32'(clr_cnt_ff) < MAP_ROWS);
         map_waddr = clr_cnt_ff[ROW_W-1:0];
         map_wdata = '0;
      end else if (s1_new) begin
         deg_we = 1'b1;
         map_we = 1'b1;
      end else if (s2_new) begin
         deg_we    = 1'b1;
         deg_waddr = s2_ff.hi;
         deg_wdata = sat_inc(deg_hi);
      end
   end

   // ---------------- clearing pass ----------------
   always_comb begin
      clear_in   = clear_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clear_ff) begin
         if (clr_cnt_ff == CLR_W'(CLEAR_LEN - 1)) begin
            clear_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         acc_ff       <= acc_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

   // ---------------- instances ----------------
   wcs_ram #(
      .WIDTH (DEG_W),
      .DEPTH (VERTEX_COUNT)
   ) u_deg_ram (
      .clock   (clock),
      .wr_en   (deg_we),
      .wr_addr (deg_waddr),
      .wr_data (deg_wdata),
      .rd_addr (deg_raddr),
      .rd_data (deg_rdata)
   );

   wcs_ram #(
      .WIDTH (MAP_WORD),
      .DEPTH (MAP_ROWS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   // two-entry result queue: the pipeline keeps moving while a result waits
   wcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data),
      .count     (q_count)
   );

endmodule

@@ design/wcs_checker.sv @@
module wcs_checker import wcs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // clearing pass holds off input and nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or result right after reset");

   // every edge occupies the RAM ports, so req_ready is low right after each transfer
   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken on consecutive cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // with 8-bit vertex numbers nothing can be out of range at this size
   a_no_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (VERTEX_COUNT >= 256)) |-> (rsp_data.edge_status != ST_RANGE))
      else $error("out-of-range status with full vertex range");

endmodule

bind wedge_counter_edge_stream_core wcs_checker u_wcs_checker (.*);
